### rtl/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// sfcp_pkg: shared types and constants of the scope frame packer
// Word layouts of both channels, the link between CRC cells, the CRC-16
// constants and a function that folds one byte into a running CRC.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcp_pkg;

    // Frame geometry: eight sample bytes followed by two CRC bytes.
    localparam int DATA_BYTES  = 8;
    localparam int FRAME_BYTES = 10;
    localparam int DATA_W      = DATA_BYTES * 8;
    localparam int CRC_W       = 16;
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int CNT_W       = $clog2(FRAME_BYTES);

    // CRC-16/MODBUS: reflected polynomial, all-ones start, no final inversion.
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;

    // Input word: four channel samples.
    typedef struct packed {
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic signed [15:0] sample_c;
        logic signed [15:0] sample_d;
    } t_in_word;

    // Output word: one frame byte and the end-of-frame marker.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_word;

    // Payload handed from one CRC cell to the next.
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CRC_W-1:0]  crc;
    } t_link;

    // Fold one byte into the CRC, least significant bit first.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                   input logic [7:0]       data_in);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/scope_frame_crc16_packer.sv
// ----------------------------------------------------------------------------
// scope_frame_crc16_packer: four-channel sample framer with CRC-16 trailer
// Packs four 16-bit samples into a ten-byte frame closed by a CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Each accepted word of four samples produces ten output words: the samples in
// channel order, low byte first, then the CRC-16/MODBUS of those eight bytes,
// low byte first, with last_byte set on the final one. The CRC runs through a
// chain of eight cells, one byte per cell, each registered ahead of
// the output register. The output register sends one byte per cycle while
// the receiver is ready, and the next frame loads as the last byte leaves;
// the chain holds up to eight further frames and keeps accepting while the
// output drains.
`default_nettype none

module scope_frame_crc16_packer (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sfcp_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sfcp_pkg::t_out_word     o_out_word
);

    localparam int NUM_CELLS = sfcp_pkg::DATA_BYTES;

    logic            w_valid [NUM_CELLS+1];
    logic            w_ready [NUM_CELLS+1];
    sfcp_pkg::t_link w_link  [NUM_CELLS+1];

    // Chain head: sample bytes laid out with channel a in the low bytes.
    assign w_valid[0]     = i_in_valid;
    assign o_in_ready     = w_ready[0];
    assign w_link[0].data = {i_in_word.sample_d, i_in_word.sample_c,
                             i_in_word.sample_b, i_in_word.sample_a};
    assign w_link[0].crc  = sfcp_pkg::CRC_INIT;

    // One CRC cell per data byte.
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        sfcp_crc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_link  (w_link[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_link  (w_link[k+1])
        );
    end

    // Output register that sends the frame one byte at a time.
    sfcp_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NUM_CELLS]),
        .o_ready (w_ready[NUM_CELLS]),
        .i_link  (w_link[NUM_CELLS]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

`default_nettype wire

### rtl/sfcp_crc_cell.sv
// ----------------------------------------------------------------------------
// sfcp_crc_cell: one byte step of the CRC chain
// Folds the low data byte into the running CRC and hands the data word on,
// rotated by one byte, so that the next cell sees the following byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcp_crc_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire sfcp_pkg::t_link i_link,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output sfcp_pkg::t_link      o_link
);

    logic            r_valid;
    logic            n_valid;
    sfcp_pkg::t_link r_link;
    sfcp_pkg::t_link n_link;

    // The cell takes a word when it is empty or its word moves on this cycle.
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_link  = r_link;

    // Next state: load, CRC one byte, and rotate the data by one byte.
    always_comb begin
        n_valid = r_valid;
        n_link  = r_link;
        if (o_ready) begin
            n_valid = i_valid;
        end
        if (o_ready && i_valid) begin
            n_link.data = {i_link.data[7:0], i_link.data[sfcp_pkg::DATA_W-1:8]};
            n_link.crc  = sfcp_pkg::crc_byte(i_link.crc, i_link.data[7:0]);
        end
    end

    // Valid flag under reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
    end

endmodule

`default_nettype wire

### rtl/sfcp_serializer.sv
// ----------------------------------------------------------------------------
// sfcp_serializer: frame output register
// Holds one finished frame and sends it one byte per word, sample bytes first
// and the CRC last; a new frame loads as the last byte leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcp_serializer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire sfcp_pkg::t_link i_link,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output sfcp_pkg::t_out_word  o_word
);

    localparam logic [sfcp_pkg::CNT_W-1:0] LAST_IDX =
        sfcp_pkg::CNT_W'(sfcp_pkg::FRAME_BYTES - 1);

    logic                         r_busy;
    logic                         n_busy;
    logic [sfcp_pkg::CNT_W-1:0]   r_cnt;
    logic [sfcp_pkg::CNT_W-1:0]   n_cnt;
    logic [sfcp_pkg::FRAME_W-1:0] r_frame;
    logic [sfcp_pkg::FRAME_W-1:0] n_frame;
    logic                         last;
    logic                         load;

    assign last    = (r_cnt == LAST_IDX);
    assign o_ready = !r_busy || (i_ready && last);
    assign load    = i_valid && o_ready;

    assign o_valid           = r_busy;
    assign o_word.frame_byte = r_frame[7:0];
    assign o_word.last_byte  = last;

    // Next state: load a frame, or shift out one byte per accepted word.
    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_frame = r_frame;
        if (load) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_frame = {i_link.crc, i_link.data};
        end else if (r_busy && i_ready) begin
            if (last) begin
                n_busy = 1'b0;
                n_cnt  = '0;
            end else begin
                n_cnt   = r_cnt + sfcp_pkg::CNT_W'(1);
                n_frame = {8'h00, r_frame[sfcp_pkg::FRAME_W-1:8]};
            end
        end
    end

    // Control under reset, frame bytes without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

`ifndef SYNTHESIS
    // An idle serializer always waits at the first byte position.
    a_idle_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_cnt == '0)
        else $error("serializer idle with nonzero byte count");

    // The last byte leaving with no frame waiting empties the register.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && i_ready && last && !i_valid |=> !r_busy)
        else $error("serializer still busy after last byte");

    // A byte taken before the end advances the count by exactly one.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && i_ready && !last |=>
            r_busy && r_cnt == $past(r_cnt) + sfcp_pkg::CNT_W'(1))
        else $error("serializer byte count did not advance");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for scope_frame_crc16_packer
// Feeds words of four samples through a valid/ready driver and checks every
// frame byte against a local CRC-16/MODBUS framer. It runs directed
// extremes, then random words under several idle and stall patterns,
// including a long output hold that backs the block up.
// ----------------------------------------------------------------------------

module tb;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int LIMIT_CYCLES = 200000;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    sfcp_pkg::t_in_word  in_word   = '0;
    logic                out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    sfcp_pkg::t_out_word o_out_word;

    // Words still to be offered and frame bytes still owed by the block.
    sfcp_pkg::t_in_word  samples_to_send[$];
    sfcp_pkg::t_out_word frame_bytes_due[$];

    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    int  hold_left       = 0;
    logic hold_kick      = 1'b0;
    int  cycle_count     = 0;
    int  mismatches      = 0;

    scope_frame_crc16_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // CRC-16/MODBUS run bit-serially over the 64-bit payload. The samples sit
    // with channel a in the low bits, so shifting out from bit 0 walks the
    // frame bytes in send order, each byte least significant bit first.
    function automatic logic [15:0] modbus_crc_of(input logic [63:0] payload);
        logic [15:0] crc;
        logic        feedback;
        crc = 16'hFFFF;
        for (int i = 0; i < 64; i++) begin
            feedback = crc[0] ^ payload[i];
            crc = crc >> 1;
            if (feedback) begin
                crc = crc ^ 16'hA001;
            end
        end
        return crc;
    endfunction

    // Expected frame for one word: eight sample bytes, then the CRC low and
    // high bytes, with the marker on the tenth byte only.
    task automatic push_frame_bytes(input sfcp_pkg::t_in_word w);
        logic [63:0]         payload;
        logic [79:0]         frame;
        sfcp_pkg::t_out_word b;
        payload = {w.sample_d, w.sample_c, w.sample_b, w.sample_a};
        frame = {modbus_crc_of(payload), payload};
        for (int k = 0; k < 10; k++) begin
            b.frame_byte = frame[8*k +: 8];
            b.last_byte  = (k == 9);
            frame_bytes_due.push_back(b);
        end
    endtask

    // Input driver: an offered word stays put until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end else begin
            if (in_valid && o_in_ready) begin
                push_frame_bytes(in_word);
            end
            if (!in_valid || o_in_ready) begin
                if (samples_to_send.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                    in_valid <= 1'b1;
                    in_word  <= samples_to_send.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold, counted down here once the stimulus kicks it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_kick) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor: each taken word is checked against the oldest due byte.
    always @(posedge i_clk) begin
        sfcp_pkg::t_out_word due;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected word, frame_byte %h last_byte %b", $time,
                             o_out_word.frame_byte, o_out_word.last_byte);
                    mismatches++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (o_out_word.frame_byte !== due.frame_byte) begin
                        $display("%0t: frame_byte expected %h actual %h", $time,
                                 due.frame_byte, o_out_word.frame_byte);
                        mismatches++;
                    end
                    if (o_out_word.last_byte !== due.last_byte) begin
                        $display("%0t: last_byte expected %b actual %b", $time,
                                 due.last_byte, o_out_word.last_byte);
                        mismatches++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("scope_frame_crc16_packer test failed");
            $finish;
        end
    end

    task automatic queue_samples(input logic [15:0] a, input logic [15:0] b,
                                 input logic [15:0] c, input logic [15:0] d);
        sfcp_pkg::t_in_word w;
        w.sample_a = a;
        w.sample_b = b;
        w.sample_c = c;
        w.sample_d = d;
        samples_to_send.push_back(w);
    endtask

    // Mostly uniform samples, with the corner values mixed in now and then.
    function automatic logic [15:0] pick_sample();
        if ($urandom_range(7) != 0) begin
            return 16'($urandom);
        end
        case ($urandom_range(4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h7FFF;
            3: return 16'h8000;
            default: return 16'h0001;
        endcase
    endfunction

    task automatic queue_random(input int count);
        @(negedge i_clk);
        for (int n = 0; n < count; n++) begin
            queue_samples(pick_sample(), pick_sample(), pick_sample(), pick_sample());
        end
    endtask

    task automatic set_idling(input int sender_pct, input int recv_pct);
        @(posedge i_clk);
        sender_idle_pct <= sender_pct;
        recv_stall_pct  <= recv_pct;
    endtask

    // Waits until every queued word is sent and every owed byte has come back.
    task automatic drain_all();
        while (samples_to_send.size() != 0 || in_valid || frame_bytes_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words: all-zero, all-one, signed extremes, byte and bit
        // patterns that separate low from high bytes and channel from channel.
        @(negedge i_clk);
        queue_samples(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_samples(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_samples(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_samples(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_samples(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        queue_samples(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001);
        queue_samples(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00);
        queue_samples(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        queue_samples(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        queue_samples(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        queue_samples(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        queue_samples(16'h0000, 16'h0100, 16'h0000, 16'h0000);
        queue_samples(16'h0000, 16'h0000, 16'h0080, 16'h0000);
        queue_samples(16'h0000, 16'h0000, 16'h0000, 16'h8000);
        drain_all();

        // Random words under each idle pattern.
        set_idling(0, 0);
        queue_random(45);
        drain_all();

        set_idling(57, 0);
        queue_random(40);
        drain_all();

        set_idling(0, 57);
        queue_random(40);

        set_idling(11, 11);
        queue_random(25);
        drain_all();

        // Back-pressure: the sender keeps offering while the output is held.
        set_idling(0, 0);
        queue_random(20);
        @(posedge i_clk);
        hold_kick <= 1'b1;
        @(posedge i_clk);
        hold_kick <= 1'b0;
        drain_all();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_bytes_due.size() == 0) begin
            $display("scope_frame_crc16_packer test passed");
        end else begin
            $display("scope_frame_crc16_packer test failed");
        end
        $finish;
    end

endmodule
